[design/akf_pkg.sv]
// ----------------------------------------------------------------------------
// akf_pkg: shared types, constants and helpers
// Fixed-point widths, register indexes, sequencer states and the rounding,
// saturation and arctangent helpers used across the altitude filter core.
// ----------------------------------------------------------------------------
package akf_pkg;

   // Number formats
   localparam int FRAC_BITS   = 16;
   localparam int DT_FRAC     = 16;
   localparam int COS_FRAC    = 30;
   localparam int W           = 32;
   localparam int NOISE_W     = 31;
   localparam int CSR_INDEX_W = 3;

   // Shared multiplier
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = MUL_P_W + 1;

   // Divider
   localparam int DIV_NUM_W = W + FRAC_BITS;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_Q_W   = DIV_NUM_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // CORDIC
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
   localparam int CORDIC_XW    = 34;
   localparam int CORDIC_ZW    = 20;
   localparam int ANGLE_W      = 16;
   localparam logic signed [CORDIC_XW-1:0] CORDIC_INIT = 34'sd652032874;
   localparam logic [ANGLE_W:0] HALF_PI_Q14 = 17'd25736;
   localparam logic [ANGLE_W:0] PI_Q14      = 17'd51472;

   // Reset values
   localparam logic [NOISE_W-1:0] PROC_NOISE_RESET = 31'd66;
   localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET = 31'd65536;
   localparam logic signed [W-1:0] P_ONE = W'(1) << FRAC_BITS;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PROC_NOISE_ALT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROC_NOISE_VEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BARO_NOISE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_NOISE    = 3'd3;

   // Request kinds
   localparam logic [1:0] KIND_PREDICT = 2'd0;
   localparam logic [1:0] KIND_BARO    = 2'd1;
   localparam logic [1:0] KIND_RANGE   = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } akf_unit_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P_D2,
      ST_P_VDT,
      ST_P_AD2,
      ST_P_ADT,
      ST_P_P11,
      ST_P_P10,
      ST_P_F01,
      ST_P_FIN,
      ST_R_COS0,
      ST_R_TILT,
      ST_R_COS1,
      ST_R_HGT,
      ST_U_S,
      ST_U_DIV0,
      ST_U_DIV1,
      ST_U_H,
      ST_U_V,
      ST_U_P00,
      ST_U_P01,
      ST_U_P10,
      ST_U_P11,
      ST_OUT
   } akf_state_type;

   // Saturate to signed 32 bits
   function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > 68'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (v < -68'sd2147483648)
         return 32'sh80000000;
      else
         return v[W-1:0];
   endfunction

   // Shift right by s, rounding half toward +infinity
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                    input int s);
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(1) <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   // Arctangent of 2^-i in Q.16 of the scaled angle
   function automatic logic signed [CORDIC_ZW-1:0] cordic_atan(
      input logic [CORDIC_IDX_W-1:0] i);
      case (i)
         4'd0:    return 20'sd51472;
         4'd1:    return 20'sd30386;
         4'd2:    return 20'sd16055;
         4'd3:    return 20'sd8150;
         4'd4:    return 20'sd4091;
         4'd5:    return 20'sd2047;
         4'd6:    return 20'sd1024;
         4'd7:    return 20'sd512;
         4'd8:    return 20'sd256;
         4'd9:    return 20'sd128;
         4'd10:   return 20'sd64;
         4'd11:   return 20'sd32;
         4'd12:   return 20'sd16;
         4'd13:   return 20'sd8;
         4'd14:   return 20'sd4;
         default: return 20'sd2;
      endcase
   endfunction

endpackage

[design/akf_mul.sv]
// ----------------------------------------------------------------------------
// akf_mul: shared signed multiplier
// One 34 x 33 signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module akf_mul import akf_pkg::*; (
   input  logic                       clock,
   input  logic signed [MUL_A_W-1:0]  op_a,
   input  logic signed [MUL_B_W-1:0]  op_b,
   output logic signed [MUL_P_W-1:0]  product
);

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   // product of the current operands, registered below
   assign product_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[design/akf_divider.sv]
// ----------------------------------------------------------------------------
// akf_divider: signed restoring divider
// One quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module akf_divider import akf_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIV_NUM_W-1:0]  dividend,
   input  logic signed [DIV_DEN_W-1:0]  divisor,
   output logic signed [DIV_Q_W-1:0]    quotient,
   output akf_unit_status_type          status
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]     rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]   quo_ff, quo_in;
   logic [DIV_DEN_W-1:0]   den_ff, den_in;
   logic [DIV_DEN_W:0]     shifted;
   logic [DIV_DEN_W:0]     diff;

   // trial subtract of the shifted remainder
   assign shifted = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DIV_NUM_W-1] ^ divisor[DIV_DEN_W-1];
         quo_in  = dividend[DIV_NUM_W-1] ? DIV_NUM_W'(-dividend) : DIV_NUM_W'(dividend);
         den_in  = divisor[DIV_DEN_W-1] ? DIV_DEN_W'(-divisor) : DIV_DEN_W'(divisor);
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // apply the sign to the magnitude quotient
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/akf_cordic.sv]
// ----------------------------------------------------------------------------
// akf_cordic: iterative CORDIC cosine
// Folds a Q2.14 angle into the first quadrant and runs one rotation per cycle;
// the cosine comes out in Q2.30.
// ----------------------------------------------------------------------------
module akf_cordic import akf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [ANGLE_W-1:0]   angle,
   output logic signed [W-1:0]         cos_value,
   output akf_unit_status_type         status
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [CORDIC_IDX_W-1:0]       idx_ff, idx_in;
   logic signed [CORDIC_XW-1:0]   x_ff, x_in;
   logic signed [CORDIC_XW-1:0]   y_ff, y_in;
   logic signed [CORDIC_ZW-1:0]   z_ff, z_in;
   logic [ANGLE_W:0]              abs_ang;
   logic [ANGLE_W:0]              fold_ang;
   logic signed [CORDIC_XW-1:0]   x_sh;
   logic signed [CORDIC_XW-1:0]   y_sh;

   // first-quadrant fold
   assign abs_ang  = angle[ANGLE_W-1] ? (ANGLE_W+1)'(-(ANGLE_W+1)'(angle))
                                      : (ANGLE_W+1)'(angle);
   assign fold_ang = (abs_ang > HALF_PI_Q14) ? PI_Q14 - abs_ang : abs_ang;

   assign x_sh = x_ff >>> idx_ff;
   assign y_sh = y_ff >>> idx_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = abs_ang > HALF_PI_Q14;
         idx_in  = '0;
         x_in    = CORDIC_INIT;
         y_in    = '0;
         z_in    = $signed(CORDIC_ZW'({fold_ang, 2'b00}));
      end else if (busy_ff) begin
         // rotate toward zero residual angle
         if (z_ff >= 0) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - cordic_atan(idx_ff);
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + cordic_atan(idx_ff);
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign cos_value   = neg_ff ? W'(-x_ff) : W'(x_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/altitude_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// altitude_kalman_filter_core: two-state altitude / velocity Kalman filter
// Sequencer driving a shared multiplier, a bit-serial divider and a CORDIC
// cosine unit over signed Q16.16 state.
//
//   channel   direction  ports                                   handshake
//   req       in         kind, measurement, time_step, angles    valid/ready
//   rsp       out        altitude/velocity estimate, skipped     valid/ready
//   csr       in         write_enable, index, write_data         write only
//
// Predict steps through the ST_P_* states; a skipped request goes straight to ST_OUT.
// A barometer update runs two 48-step divisions, one for each gain.
// A range update adds two 16-step CORDIC runs before the same update.
// One request at a time; req_ready is high only while idle.
// The result waits in an output register; a stalled rsp holds the core in
// its final state until the previous result is taken.
// Reset is synchronous and restores state, covariance and noise registers.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_core import akf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic signed [W-1:0]        req_measurement,
   input  logic [15:0]                req_time_step,
   input  logic signed [ANGLE_W-1:0]  req_pitch_angle,
   input  logic signed [ANGLE_W-1:0]  req_roll_angle,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [W-1:0]        rsp_altitude_estimate,
   output logic signed [W-1:0]        rsp_velocity_estimate,
   output logic                       rsp_skipped,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [NOISE_W-1:0]         csr_write_data
);

   akf_state_type state_ff, state_in;

   logic signed [W-1:0]       meas_ff, meas_in;
   logic [15:0]               dt_ff, dt_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [W-1:0]       alt_ff, alt_in;
   logic signed [W-1:0]       vel_ff, vel_in;
   logic signed [W-1:0]       p00_ff, p00_in;
   logic signed [W-1:0]       p01_ff, p01_in;
   logic signed [W-1:0]       p10_ff, p10_in;
   logic signed [W-1:0]       p11_ff, p11_in;
   logic [NOISE_W-1:0]        qa_ff, qa_in;
   logic [NOISE_W-1:0]        qv_ff, qv_in;
   logic [NOISE_W-1:0]        rb_ff, rb_in;
   logic [NOISE_W-1:0]        rr_ff, rr_in;
   logic [NOISE_W-1:0]        r_ff, r_in;
   logic signed [W-1:0]       z_ff, z_in;
   logic signed [W-1:0]       y_ff, y_in;
   logic signed [W-1:0]       k0_ff, k0_in;
   logic signed [W-1:0]       k1_ff, k1_in;
   logic signed [DIV_DEN_W-1:0] s_ff, s_in;
   logic [16:0]               d2_ff, d2_in;
   logic signed [MUL_A_W-1:0] hacc_ff, hacc_in;
   logic signed [MUL_A_W-1:0] f01_ff, f01_in;
   logic signed [MUL_A_W-1:0] f00_ff, f00_in;
   logic signed [W-1:0]       t0_ff, t0_in;
   logic signed [W-1:0]       t1_ff, t1_in;
   logic signed [W-1:0]       t2_ff, t2_in;
   logic                      skip_ff, skip_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]       rsp_alt_ff, rsp_alt_in;
   logic signed [W-1:0]       rsp_vel_ff, rsp_vel_in;
   logic                      rsp_skip_ff, rsp_skip_in;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   mul_product;
   logic signed [ACC_W-1:0]     prod_x;
   logic signed [ACC_W-1:0]     acc;
   logic signed [DIV_DEN_W-1:0] s_sum;

   logic                        div_start;
   logic signed [DIV_NUM_W-1:0] div_dividend;
   logic signed [DIV_DEN_W-1:0] div_divisor;
   logic signed [DIV_Q_W-1:0]   div_quotient;
   akf_unit_status_type         div_status;

   logic                        cordic_start;
   logic signed [ANGLE_W-1:0]   cordic_angle;
   logic signed [W-1:0]         cos_value;
   akf_unit_status_type         cordic_status;

   logic signed [MUL_B_W-1:0]   dt_b;

   akf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_product)
   );

   akf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   akf_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cordic_start),
      .angle     (cordic_angle),
      .cos_value (cos_value),
      .status    (cordic_status)
   );

   assign prod_x    = ACC_W'(mul_product);
   assign dt_b      = $signed(MUL_B_W'(dt_ff));
   assign req_ready = (state_ff == ST_IDLE);
   assign s_sum     = DIV_DEN_W'(p00_ff) + $signed(DIV_DEN_W'(r_ff));

   // sequencer: next state, datapath updates and unit control
   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      pitch_in     = pitch_ff;
      alt_in       = alt_ff;
      vel_in       = vel_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      qa_in        = qa_ff;
      qv_in        = qv_ff;
      rb_in        = rb_ff;
      rr_in        = rr_ff;
      r_in         = r_ff;
      z_in         = z_ff;
      y_in         = y_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      s_in         = s_ff;
      d2_in        = d2_ff;
      hacc_in      = hacc_ff;
      f01_in       = f01_ff;
      f00_in       = f00_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_alt_in   = rsp_alt_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_skip_in  = rsp_skip_ff;
      mul_a        = '0;
      mul_b        = '0;
      acc          = '0;
      div_start    = 1'b0;
      div_dividend = {p10_ff, {FRAC_BITS{1'b0}}};
      div_divisor  = s_ff;
      cordic_start = 1'b0;
      cordic_angle = pitch_ff;

      // noise register writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROC_NOISE_ALT: qa_in = csr_write_data;
            CSR_PROC_NOISE_VEL: qv_in = csr_write_data;
            CSR_BARO_NOISE:     rb_in = csr_write_data;
            CSR_RANGE_NOISE:    rr_in = csr_write_data;
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = req_measurement;
               dt_in    = req_time_step;
               pitch_in = req_pitch_angle;
               z_in     = req_measurement;
               skip_in  = 1'b0;
               case (req_kind)
                  KIND_PREDICT: begin
                     if (req_time_step == '0) begin
                        skip_in  = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_P_D2;
                     end
                  end
                  KIND_BARO: begin
                     r_in     = rb_ff;
                     state_in = ST_U_S;
                  end
                  KIND_RANGE: begin
                     cordic_start = 1'b1;
                     cordic_angle = req_roll_angle;
                     state_in     = ST_R_COS0;
                  end
                  default: begin
                     skip_in  = 1'b1;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end

         // predict
         ST_P_D2: begin
            mul_a    = $signed(MUL_A_W'(dt_ff));
            mul_b    = dt_b;
            state_in = ST_P_VDT;
         end
         ST_P_VDT: begin
            d2_in    = 17'(rnd(prod_x, DT_FRAC));
            mul_a    = MUL_A_W'(vel_ff);
            mul_b    = dt_b;
            state_in = ST_P_AD2;
         end
         ST_P_AD2: begin
            hacc_in  = MUL_A_W'(rnd(prod_x, DT_FRAC));
            mul_a    = MUL_A_W'(meas_ff);
            mul_b    = $signed(MUL_B_W'(d2_ff));
            state_in = ST_P_ADT;
         end
         ST_P_ADT: begin
            acc      = ACC_W'(alt_ff) + ACC_W'(hacc_ff) + rnd(prod_x, DT_FRAC + 1);
            alt_in   = sat32(acc);
            mul_a    = MUL_A_W'(meas_ff);
            mul_b    = dt_b;
            state_in = ST_P_P11;
         end
         ST_P_P11: begin
            acc      = ACC_W'(vel_ff) + rnd(prod_x, DT_FRAC);
            vel_in   = sat32(acc);
            mul_a    = MUL_A_W'(p11_ff);
            mul_b    = dt_b;
            state_in = ST_P_P10;
         end
         ST_P_P10: begin
            acc      = rnd(prod_x, DT_FRAC);
            f01_in   = MUL_A_W'(ACC_W'(p01_ff) + acc);
            t2_in    = sat32(ACC_W'(p10_ff) + acc);
            mul_a    = MUL_A_W'(p10_ff);
            mul_b    = dt_b;
            state_in = ST_P_F01;
         end
         ST_P_F01: begin
            f00_in   = MUL_A_W'(ACC_W'(p00_ff) + rnd(prod_x, DT_FRAC));
            mul_a    = f01_ff;
            mul_b    = dt_b;
            state_in = ST_P_FIN;
         end
         ST_P_FIN: begin
            acc      = ACC_W'(f00_ff) + rnd(prod_x, DT_FRAC) + $signed(ACC_W'(qa_ff));
            p00_in   = sat32(acc);
            p01_in   = sat32(ACC_W'(f01_ff));
            p10_in   = t2_ff;
            p11_in   = sat32(ACC_W'(p11_ff) + $signed(ACC_W'(qv_ff)));
            state_in = ST_OUT;
         end

         // range: tilt-compensate the distance
         ST_R_COS0: begin
            mul_a = MUL_A_W'(meas_ff);
            mul_b = MUL_B_W'(cos_value);
            if (cordic_status.done)
               state_in = ST_R_TILT;
         end
         ST_R_TILT: begin
            t0_in        = sat32(rnd(prod_x, COS_FRAC));
            cordic_start = 1'b1;
            state_in     = ST_R_COS1;
         end
         ST_R_COS1: begin
            mul_a = MUL_A_W'(t0_ff);
            mul_b = MUL_B_W'(cos_value);
            if (cordic_status.done)
               state_in = ST_R_HGT;
         end
         ST_R_HGT: begin
            z_in     = sat32(rnd(prod_x, COS_FRAC));
            r_in     = rr_ff;
            state_in = ST_U_S;
         end

         // scalar measurement update
         ST_U_S: begin
            if (s_sum == '0) begin
               skip_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               s_in         = s_sum;
               y_in         = sat32(ACC_W'(z_ff) - ACC_W'(alt_ff));
               div_start    = 1'b1;
               div_dividend = {p00_ff, {FRAC_BITS{1'b0}}};
               div_divisor  = s_sum;
               state_in     = ST_U_DIV0;
            end
         end
         ST_U_DIV0: begin
            if (div_status.done) begin
               k0_in     = sat32(ACC_W'(div_quotient));
               div_start = 1'b1;
               state_in  = ST_U_DIV1;
            end
         end
         ST_U_DIV1: begin
            mul_a = MUL_A_W'(k0_ff);
            mul_b = MUL_B_W'(y_ff);
            if (div_status.done) begin
               k1_in    = sat32(ACC_W'(div_quotient));
               state_in = ST_U_H;
            end
         end
         ST_U_H: begin
            alt_in   = sat32(ACC_W'(alt_ff) + rnd(prod_x, FRAC_BITS));
            mul_a    = MUL_A_W'(k1_ff);
            mul_b    = MUL_B_W'(y_ff);
            state_in = ST_U_V;
         end
         ST_U_V: begin
            vel_in   = sat32(ACC_W'(vel_ff) + rnd(prod_x, FRAC_BITS));
            mul_a    = MUL_A_W'(k0_ff);
            mul_b    = MUL_B_W'(p00_ff);
            state_in = ST_U_P00;
         end
         ST_U_P00: begin
            t0_in    = sat32(ACC_W'(p00_ff) - rnd(prod_x, FRAC_BITS));
            mul_a    = MUL_A_W'(k0_ff);
            mul_b    = MUL_B_W'(p01_ff);
            state_in = ST_U_P01;
         end
         ST_U_P01: begin
            t1_in    = sat32(ACC_W'(p01_ff) - rnd(prod_x, FRAC_BITS));
            mul_a    = MUL_A_W'(k1_ff);
            mul_b    = MUL_B_W'(p00_ff);
            state_in = ST_U_P10;
         end
         ST_U_P10: begin
            t2_in    = sat32(ACC_W'(p10_ff) - rnd(prod_x, FRAC_BITS));
            mul_a    = MUL_A_W'(k1_ff);
            mul_b    = MUL_B_W'(p01_ff);
            state_in = ST_U_P11;
         end
         ST_U_P11: begin
            p11_in   = sat32(ACC_W'(p11_ff) - rnd(prod_x, FRAC_BITS));
            p00_in   = t0_ff;
            p01_in   = t1_ff;
            p10_in   = t2_ff;
            state_in = ST_OUT;
         end

         // hand the result to the output register
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in   = alt_ff;
               rsp_vel_in   = vel_ff;
               rsp_skip_in  = skip_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         alt_ff       <= '0;
         vel_ff       <= '0;
         p00_ff       <= P_ONE;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= P_ONE;
         qa_ff        <= PROC_NOISE_RESET;
         qv_ff        <= PROC_NOISE_RESET;
         rb_ff        <= MEAS_NOISE_RESET;
         rr_ff        <= MEAS_NOISE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alt_ff       <= alt_in;
         vel_ff       <= vel_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         qa_ff        <= qa_in;
         qv_ff        <= qv_in;
         rb_ff        <= rb_in;
         rr_ff        <= rr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      dt_ff       <= dt_in;
      pitch_ff    <= pitch_in;
      r_ff        <= r_in;
      z_ff        <= z_in;
      y_ff        <= y_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      s_ff        <= s_in;
      d2_ff       <= d2_in;
      hacc_ff     <= hacc_in;
      f01_ff      <= f01_in;
      f00_ff      <= f00_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      skip_ff     <= skip_in;
      rsp_alt_ff  <= rsp_alt_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_skip_ff <= rsp_skip_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_altitude_estimate = rsp_alt_ff;
   assign rsp_velocity_estimate = rsp_vel_ff;
   assign rsp_skipped           = rsp_skip_ff;

   // an accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

   // a new result only comes from the final state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside final state");

   // shared units are never restarted while running
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_cordic_start: assert property (@(posedge clock) disable iff (reset)
      cordic_start |-> !cordic_status.busy)
      else $error("cordic started while busy");

endmodule
